[design/ssatc_pkg.sv]
`default_nettype none
package ssatc_pkg;

    // Field widths
    localparam int TICKS_W  = 17;
    localparam int SERVO_W  = 14;
    localparam int MCMD_W   = 2;
    localparam int LEVEL_W  = 16;
    localparam int DUR_W    = 11;
    localparam int DIST_W   = 16;
    localparam int THRESH_W = 11;
    localparam int STEP_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Servo limits
    localparam int SERVO_MIN    = 300;
    localparam int SERVO_MAX    = 8000;
    localparam int SERVO_CENTRE = SERVO_MAX / 2;

    // Distance: ticks * 0.0343 / 2 cm in 1/16 cm, as (ticks * 17985) >> 16
    localparam int DIST_SCALE = 17985;

    // Angle: sweep * 180 / SERVO_MAX == sweep * 9 / 400
    localparam int ANG_NUM      = 9;
    localparam int ANG_DIV      = 400;
    localparam int ANG_RECIP    = 41943;   // floor(2^24 / 400)
    localparam int ANG_SHIFT    = 24;
    localparam int ANGLE_MID    = 90;

    // Turn time: diff * 1750 / 90 == diff * 175 / 9
    localparam int TURN_NUM     = 175;
    localparam int TURN_RECIP   = 58255;   // ceil(2^19 / 9)
    localparam int TURN_SHIFT   = 19;

    // Motor commands
    localparam logic [MCMD_W-1:0] MOTOR_STOP  = 2'd0;
    localparam logic [MCMD_W-1:0] MOTOR_FWD   = 2'd1;
    localparam logic [MCMD_W-1:0] MOTOR_RIGHT = 2'd2;
    localparam logic [MCMD_W-1:0] MOTOR_LEFT  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DETECT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED  = 2'd3;

    localparam logic [THRESH_W-1:0] DETECT_RESET = 11'd335;
    localparam logic [THRESH_W-1:0] STOP_RESET   = 11'd67;
    localparam logic [STEP_W-1:0]   STEP_RESET   = 8'd50;
    localparam logic [LEVEL_W-1:0]  SPEED_RESET  = 16'd14286;

    typedef struct packed {
        logic load;
        logic angle;
        logic quot;
        logic scale;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

[design/ssatc_meas_if.sv]
`default_nettype none
interface ssatc_meas_if;
    import ssatc_pkg::*;

    logic               valid;
    logic               ready;
    logic [TICKS_W-1:0] echo_ticks;
    logic               echo_valid;

    modport source (output valid, output echo_ticks, output echo_valid, input ready);
    modport sink   (input valid, input echo_ticks, input echo_valid, output ready);
endinterface
`default_nettype wire

[design/ssatc_res_if.sv]
`default_nettype none
interface ssatc_res_if;
    import ssatc_pkg::*;

    logic               valid;
    logic               ready;
    logic [SERVO_W-1:0] servo_position;
    logic [MCMD_W-1:0]  motor_command;
    logic [LEVEL_W-1:0] motor_level;
    logic [DUR_W-1:0]   turn_duration_ms;
    logic               object_seen;
    logic [DIST_W-1:0]  distance_sixteenths;

    modport source (
        output valid, output servo_position, output motor_command, output motor_level,
        output turn_duration_ms, output object_seen, output distance_sixteenths,
        input ready
    );
    modport sink (
        input valid, input servo_position, input motor_command, input motor_level,
        input turn_duration_ms, input object_seen, input distance_sixteenths,
        output ready
    );
endinterface
`default_nettype wire

[design/ssatc_ctrl.sv]
`default_nettype none
module ssatc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire ssatc_pkg::t_status i_status,
    output ssatc_pkg::t_cmd        o_cmd
);
    import ssatc_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ANGLE  = 3'd1;
    localparam logic [2:0] S_QUOT   = 3'd2;
    localparam logic [2:0] S_SCALE  = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ANGLE;
                end
            end
            S_ANGLE: begin
                o_cmd.angle = 1'b1;
                n_state     = S_QUOT;
            end
            S_QUOT: begin
                o_cmd.quot = 1'b1;
                n_state    = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_COMMIT;
            end
            S_COMMIT: begin
                // hold until the result register can take the transfer
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

[design/ssatc_dp.sv]
`default_nettype none
module ssatc_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [ssatc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ssatc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire ssatc_pkg::t_cmd                   i_cmd,
    output ssatc_pkg::t_status                     o_status,
    input  wire logic [ssatc_pkg::TICKS_W-1:0]     i_echo_ticks,
    input  wire logic                              i_echo_valid,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic [ssatc_pkg::SERVO_W-1:0]          o_servo_position,
    output logic [ssatc_pkg::MCMD_W-1:0]           o_motor_command,
    output logic [ssatc_pkg::LEVEL_W-1:0]          o_motor_level,
    output logic [ssatc_pkg::DUR_W-1:0]            o_turn_duration_ms,
    output logic                                   o_object_seen,
    output logic [ssatc_pkg::DIST_W-1:0]           o_distance_sixteenths
);
    import ssatc_pkg::*;

    // configuration
    logic [THRESH_W-1:0] r_detect;
    logic [THRESH_W-1:0] r_stop;
    logic [STEP_W-1:0]   r_step;
    logic [LEVEL_W-1:0]  r_speed;

    // tracking state
    logic [DIST_W-1:0]  r_dist;
    logic [SERVO_W-1:0] r_sweep;
    logic               r_desc;
    logic               r_aligned;
    logic               r_seen_before;
    logic [SERVO_W-1:0] r_servo;

    // per-item working registers
    logic        r_seen;
    logic        r_fwd;
    logic [9:0]  r_aq0;
    logic [8:0]  r_angle;
    logic        r_right;
    logic [15:0] r_sprod;

    // result register
    logic               r_out_valid;
    logic [SERVO_W-1:0] r_o_servo;
    logic [MCMD_W-1:0]  r_o_cmd;
    logic [LEVEL_W-1:0] r_o_level;
    logic [DUR_W-1:0]   r_o_dur;
    logic               r_o_seen;
    logic [DIST_W-1:0]  r_o_dist;

    logic [31:0] w_dprod;
    logic [17:0] w_x;
    logic [33:0] w_aprod;
    logic [17:0] w_rem;
    logic [9:0]  w_angle10;
    logic [8:0]  w_diff;
    logic [31:0] w_tprod;
    logic [DUR_W-1:0] w_dur;

    logic [SERVO_W-1:0] n_base;
    logic [SERVO_W-1:0] n_sweep;
    logic               n_desc;

    assign w_dprod   = 32'(i_echo_ticks) * 32'(DIST_SCALE);
    assign w_x       = 18'(r_sweep) * 18'(ANG_NUM);
    assign w_aprod   = 34'(w_x) * 34'(ANG_RECIP);
    assign w_rem     = w_x - 18'(r_aq0) * 18'(ANG_DIV);
    // reciprocal estimate is at most one low
    assign w_angle10 = r_aq0 + 10'(w_rem >= 18'(ANG_DIV));
    assign w_diff    = (r_angle < 9'(ANGLE_MID)) ? 9'(ANGLE_MID) - r_angle
                                                 : r_angle - 9'(ANGLE_MID);
    assign w_tprod   = 32'(r_sprod) * 32'(TURN_RECIP);
    assign w_dur     = w_tprod[TURN_SHIFT+DUR_W-1:TURN_SHIFT];

    // sweep step, restarting from centre when the object was just lost
    always_comb begin
        n_base = r_seen_before ? SERVO_W'(SERVO_CENTRE) : r_sweep;
        if (r_desc) begin
            n_sweep = (SERVO_W'(r_step) > n_base) ? '0 : n_base - SERVO_W'(r_step);
        end else begin
            n_sweep = n_base + SERVO_W'(r_step);
        end
        n_desc = r_desc;
        if (n_sweep > SERVO_W'(SERVO_MAX)) begin
            n_desc = 1'b1;
        end
        if (n_sweep < SERVO_W'(SERVO_MIN)) begin
            n_desc = 1'b0;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detect <= DETECT_RESET;
            r_stop   <= STOP_RESET;
            r_step   <= STEP_RESET;
            r_speed  <= SPEED_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DETECT: r_detect <= i_cfg_data[THRESH_W-1:0];
                CFG_STOP:   r_stop   <= i_cfg_data[THRESH_W-1:0];
                CFG_STEP:   r_step   <= i_cfg_data[STEP_W-1:0];
                CFG_SPEED:  r_speed  <= i_cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // working pipeline, payload only
    always_ff @(posedge i_clk) begin
        if (i_cmd.angle) begin
            r_seen <= r_dist < {1'b0, r_detect, 4'b0000};
            r_fwd  <= r_dist > {1'b0, r_stop, 4'b0000};
            r_aq0  <= w_aprod[ANG_SHIFT+9:ANG_SHIFT];
        end
        if (i_cmd.quot) begin
            r_angle <= w_angle10[8:0];
        end
        if (i_cmd.scale) begin
            r_right <= r_angle < 9'(ANGLE_MID);
            r_sprod <= 16'(w_diff) * 16'(TURN_NUM);
        end
        if (i_cmd.commit) begin
            r_o_seen <= r_seen;
            r_o_dist <= r_dist;
            r_o_cmd   <= MOTOR_STOP;
            r_o_level <= '0;
            r_o_dur   <= '0;
            if (r_seen) begin
                if (!r_aligned) begin
                    r_o_cmd   <= r_right ? MOTOR_RIGHT : MOTOR_LEFT;
                    r_o_level <= r_speed;
                    r_o_dur   <= w_dur;
                    r_o_servo <= SERVO_W'(SERVO_CENTRE);
                end else begin
                    r_o_servo <= r_servo;
                    if (r_fwd) begin
                        r_o_cmd   <= MOTOR_FWD;
                        r_o_level <= r_speed;
                    end
                end
            end else begin
                r_o_servo <= n_base;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist        <= '0;
            r_sweep       <= SERVO_W'(SERVO_MIN);
            r_desc        <= 1'b0;
            r_aligned     <= 1'b0;
            r_seen_before <= 1'b0;
            r_servo       <= SERVO_W'(SERVO_MIN);
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.load && i_echo_valid) begin
                r_dist <= w_dprod[31:16];
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
                if (r_seen) begin
                    r_seen_before <= 1'b1;
                    if (!r_aligned) begin
                        r_servo   <= SERVO_W'(SERVO_CENTRE);
                        r_aligned <= 1'b1;
                    end
                end else begin
                    r_seen_before <= 1'b0;
                    r_aligned     <= 1'b0;
                    r_servo       <= n_base;
                    r_sweep       <= n_sweep;
                    r_desc        <= n_desc;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_servo_position      = r_o_servo;
    assign o_motor_command       = r_o_cmd;
    assign o_motor_level         = r_o_level;
    assign o_turn_duration_ms    = r_o_dur;
    assign o_object_seen         = r_o_seen;
    assign o_distance_sixteenths = r_o_dist;

endmodule
`default_nettype wire

[design/sonar_search_and_track_controller_unit.sv]
// Sonar search-and-track controller. Each measurement transfer (echo ticks and a
// valid flag) yields exactly one result transfer: servo compare, motor command
// (stop, forward, turn right, turn left), wheel level, turn time in ms, a seen
// flag and the stored distance in 1/16 cm. A measurement is accepted and its
// echo time converted; three steps do the servo-angle and turn-time constant
// multiplies, and a commit step writes the result register, waiting while an
// earlier result is still held. No new measurement is taken before the commit.
// The user must write the configuration registers via i_cfg_we / i_cfg_index /
// i_cfg_data while no measurement is in flight; the block does not enforce this.
`default_nettype none
module sonar_search_and_track_controller_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [ssatc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ssatc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    ssatc_meas_if.sink                             i_meas,
    ssatc_res_if.source                            o_res
);
    import ssatc_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    ssatc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_meas.valid),
        .o_in_ready (i_meas.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ssatc_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .i_cmd                 (w_cmd),
        .o_status              (w_status),
        .i_echo_ticks          (i_meas.echo_ticks),
        .i_echo_valid          (i_meas.echo_valid),
        .i_out_ready           (o_res.ready),
        .o_out_valid           (o_res.valid),
        .o_servo_position      (o_res.servo_position),
        .o_motor_command       (o_res.motor_command),
        .o_motor_level         (o_res.motor_level),
        .o_turn_duration_ms    (o_res.turn_duration_ms),
        .o_object_seen         (o_res.object_seen),
        .o_distance_sixteenths (o_res.distance_sixteenths)
    );

endmodule
`default_nettype wire

[design/ssatc_checker.sv]
`default_nettype none
module ssatc_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_res_valid,
    input wire logic                          i_res_ready,
    input wire logic [ssatc_pkg::MCMD_W-1:0]  i_motor_command,
    input wire logic [ssatc_pkg::LEVEL_W-1:0] i_motor_level,
    input wire logic [ssatc_pkg::DUR_W-1:0]   i_turn_duration_ms,
    input wire logic                          i_object_seen
);
    import ssatc_pkg::*;

    // a stalled result holds its command
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_motor_command))
        else $error("result dropped or changed while stalled");

    a_dur_only_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_motor_command == MOTOR_STOP || i_motor_command == MOTOR_FWD)
        |-> i_turn_duration_ms == '0)
        else $error("turn time given without a turn");

    a_stop_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_motor_command == MOTOR_STOP |-> i_motor_level == '0)
        else $error("wheels driven while stopped");

    a_no_object_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_object_seen |-> i_motor_command == MOTOR_STOP)
        else $error("motion without a detected object");

endmodule

bind sonar_search_and_track_controller_unit ssatc_checker u_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_res_valid        (o_res.valid),
    .i_res_ready        (o_res.ready),
    .i_motor_command    (o_res.motor_command),
    .i_motor_level      (o_res.motor_level),
    .i_turn_duration_ms (o_res.turn_duration_ms),
    .i_object_seen      (o_res.object_seen)
);
`default_nettype wire
